@@ hw/rtl/serial_frame_deframer_defines.svh @@
// Assertion macros for the serial frame deframer.
// Uses clk_i and rst_ni of the module that includes it; no other dependencies.
`ifndef SERIAL_FRAME_DEFRAMER_DEFINES_SVH
`define SERIAL_FRAME_DEFRAMER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge outside reset.
`define SFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFD_ASSERT_IMPL(lbl, ante, cons, msg)
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/sfd_pkg.sv @@
// Types and constants shared by the serial frame deframer.
// No dependencies.
package sfd_pkg;

  localparam logic [7:0] HDR_HI_BYTE = 8'h55;
  localparam logic [7:0] HDR_LO_BYTE = 8'hAA;
  localparam logic [7:0] CMD_UNIT_A  = 8'h06;
  localparam logic [7:0] CMD_UNIT_B  = 8'h07;
  localparam logic [7:0] CMD_UNIT_C  = 8'h22;
  localparam logic [7:0] CMD_UNIT_D  = 8'h26;

  localparam logic [15:0] MAX_LEN_RESET = 16'd249;

  typedef enum logic [2:0] {
    PH_HDR_HI,
    PH_HDR_LO,
    PH_VERSION,
    PH_COMMAND,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_CHECK
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_DROP,
    ROLE_HEADER,
    ROLE_VERSION,
    ROLE_COMMAND,
    ROLE_LENGTH,
    ROLE_PAYLOAD,
    ROLE_CHECK
  } role_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    role_e       byte_role;
    logic [15:0] payload_position;
    logic        frame_end;
    logic        frame_abort;
    logic        checksum_ok;
    logic        unit_command;
  } result_t;

endpackage

@@ hw/rtl/sfd_in_if.sv @@
// Received-byte request channel of the serial frame deframer.
// No dependencies.
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/sfd_out_if.sv @@
// Result request channel of the serial frame deframer.
// No dependencies.
interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [2:0]  byte_role;
  logic [15:0] payload_position;
  logic        frame_end;
  logic        frame_abort;
  logic        checksum_ok;
  logic        unit_command;

  modport source (output valid, output data_byte, output byte_role,
                  output payload_position, output frame_end, output frame_abort,
                  output checksum_ok, output unit_command, input ready);
  modport sink (input valid, input data_byte, input byte_role,
                input payload_position, input frame_end, input frame_abort,
                input checksum_ok, input unit_command, output ready);
endinterface

@@ hw/rtl/sfd_parser.sv @@
// Frame parse state machine: holds phase, length, count, sum and command,
// and classifies one byte per step. Depends on sfd_pkg.
module sfd_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      byte_i,
  input  logic [15:0]     max_len_i,
  output sfd_pkg::result_t res_o
);
  import sfd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  cmd_q, cmd_d;

  logic [15:0] full_len;
  logic [15:0] cnt_inc;
  logic [7:0]  sum_add;

  assign full_len = {len_q[15:8], byte_i};
  assign cnt_inc  = cnt_q + 16'd1;
  assign sum_add  = sum_q + byte_i;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    cmd_d   = cmd_q;
    case (phase_q)
      PH_HDR_HI: begin
        if (byte_i == HDR_HI_BYTE) begin
          sum_d   = byte_i;
          phase_d = PH_HDR_LO;
        end
      end
      PH_HDR_LO: begin
        // A wrong second byte closes the frame; it is not re-examined as a header.
        if (byte_i == HDR_LO_BYTE) begin
          sum_d   = sum_add;
          phase_d = PH_VERSION;
        end else begin
          phase_d = PH_HDR_HI;
        end
      end
      PH_VERSION: begin
        sum_d   = sum_add;
        phase_d = PH_COMMAND;
      end
      PH_COMMAND: begin
        sum_d   = sum_add;
        cmd_d   = byte_i;
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        sum_d   = sum_add;
        len_d   = {byte_i, 8'h00};
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        sum_d = sum_add;
        cnt_d = '0;
        if (full_len > max_len_i) begin
          len_d   = '0;
          phase_d = PH_HDR_HI;
        end else if (full_len == 16'd0) begin
          len_d   = full_len;
          phase_d = PH_CHECK;
        end else begin
          len_d   = full_len;
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_d = sum_add;
        cnt_d = cnt_inc;
        if (cnt_inc >= len_q) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        len_d   = '0;
        phase_d = PH_HDR_HI;
      end
      default: begin
        phase_d = PH_HDR_HI;
      end
    endcase
  end

  always_comb begin
    res_o                  = '0;
    res_o.data_byte        = byte_i;
    res_o.byte_role        = ROLE_DROP;
    case (phase_q)
      PH_HDR_HI: begin
        if (byte_i == HDR_HI_BYTE) begin
          res_o.byte_role = ROLE_HEADER;
        end
      end
      PH_HDR_LO: begin
        if (byte_i == HDR_LO_BYTE) begin
          res_o.byte_role = ROLE_HEADER;
        end else begin
          res_o.frame_abort = 1'b1;
        end
      end
      PH_VERSION: res_o.byte_role = ROLE_VERSION;
      PH_COMMAND: res_o.byte_role = ROLE_COMMAND;
      PH_LEN_HI:  res_o.byte_role = ROLE_LENGTH;
      PH_LEN_LO: begin
        res_o.byte_role   = ROLE_LENGTH;
        res_o.frame_abort = (full_len > max_len_i);
      end
      PH_PAYLOAD: begin
        res_o.byte_role        = ROLE_PAYLOAD;
        res_o.payload_position = cnt_q;
      end
      PH_CHECK: begin
        res_o.byte_role    = ROLE_CHECK;
        res_o.frame_end    = 1'b1;
        res_o.checksum_ok  = (sum_q == byte_i);
        res_o.unit_command = (cmd_q inside {CMD_UNIT_A, CMD_UNIT_B, CMD_UNIT_C, CMD_UNIT_D});
      end
      default: res_o.byte_role = ROLE_DROP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR_HI;
      len_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      cmd_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      cmd_q   <= cmd_d;
    end
  end

endmodule

@@ hw/rtl/sfd_result_reg.sv @@
// Result register driving the output channel; holds a result while stalled.
// Depends on sfd_pkg and sfd_out_if.
module sfd_result_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  sfd_pkg::result_t res_i,
  output logic             ready_o,
  sfd_out_if.source        out_chan_o
);
  import sfd_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  assign ready_o = !vld_q || out_chan_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_chan_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_chan_o.valid            = vld_q;
  assign out_chan_o.data_byte        = res_q.data_byte;
  assign out_chan_o.byte_role        = 3'(res_q.byte_role);
  assign out_chan_o.payload_position = res_q.payload_position;
  assign out_chan_o.frame_end        = res_q.frame_end;
  assign out_chan_o.frame_abort      = res_q.frame_abort;
  assign out_chan_o.checksum_ok      = res_q.checksum_ok;
  assign out_chan_o.unit_command     = res_q.unit_command;

endmodule

@@ hw/rtl/serial_frame_deframer.sv @@
// Serial frame deframer, top level. Depends on sfd_pkg, sfd_in_if, sfd_out_if,
// sfd_parser, sfd_result_reg and serial_frame_deframer_defines.svh.
//
// Takes one received byte per request and tags it within frames of the form
// 55 AA, version, command, big-endian 16-bit length, payload, checksum; every
// byte yields exactly one result. The block accepts a byte in every cycle
// while the output is not stalled. A byte is held in the input register, and
// its result is loaded into the result register when that register can take
// it; the result is then presented on the output channel until it is taken.
// A stalled output holds the result register and then the input register, so
// input stalls only when both are full. The parse state is updated as each
// byte leaves the input register. max_len_q resets to 249 and is written
// through cfg_we_i/cfg_wdata_i; the user must write it only while no frame
// bytes are in flight, and the block itself does not enforce this.
`include "serial_frame_deframer_defines.svh"

module serial_frame_deframer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  sfd_in_if.sink       in_chan_i,
  sfd_out_if.source    out_chan_o
);
  import sfd_pkg::*;

  logic [15:0] max_len_q;
  logic        in_vld_q, in_vld_d;
  logic [7:0]  in_byte_q;
  logic        res_ready;
  logic        advance;
  result_t     res;

  assign advance         = in_vld_q && res_ready;
  assign in_chan_i.ready = !in_vld_q || res_ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_chan_i.valid && in_chan_i.ready) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      max_len_q <= MAX_LEN_RESET;
    end else begin
      in_vld_q <= in_vld_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan_i.valid && in_chan_i.ready) begin
      in_byte_q <= in_chan_i.rx_byte;
    end
  end

  sfd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .max_len_i (max_len_q),
    .res_o     (res)
  );

  sfd_result_reg u_result_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .res_i      (res),
    .ready_o    (res_ready),
    .out_chan_o (out_chan_o)
  );

  // A frame end is always a checksum byte and never discards a frame.
  `SFD_ASSERT_IMPL(a_end_is_check, out_chan_o.valid && out_chan_o.frame_end, (out_chan_o.byte_role == 3'(ROLE_CHECK)) && !out_chan_o.frame_abort, "frame end on a byte that is not a clean checksum")
  // Only payload bytes carry a position.
  `SFD_ASSERT_IMPL(a_pos_payload_only, out_chan_o.valid && (out_chan_o.byte_role != 3'(ROLE_PAYLOAD)), out_chan_o.payload_position == 16'd0, "payload position set outside the payload")
  // A byte held in the input register stays there until the result register takes it.
  `SFD_ASSERT_NEXT(a_in_hold, in_vld_q && !advance, in_vld_q && $stable(in_byte_q), "pending byte lost from the input register")

endmodule
